/* src/mtep_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

    localparam int COUNT_BITS    = 32;
    localparam int LINE_BITS     = 16;
    localparam int LIMIT_BITS    = 16;
    localparam int PCT_BITS      = 7;
    localparam int OUT_LINE_BITS = 16;
    localparam int CMP_BITS      = (LINE_BITS > LIMIT_BITS) ? LINE_BITS : LIMIT_BITS;
    localparam int PROD_BITS     = COUNT_BITS + 8;
    localparam int ADDR_BITS     = 4;
    localparam int DATA_BITS     = 32;
    localparam int PROG_BITS     = 3;

    localparam logic [PROG_BITS-1:0] FROM_LEN = PROG_BITS'(5);
    localparam logic [7:0] NEWLINE_CHAR      = 8'h0A;
    localparam logic [7:0] NUL_CHAR          = 8'h00;
    localparam logic [7:0] B64_SCALE         = 8'd100;

    typedef enum logic [1:0] {
        ENC_DEFAULT = 2'd0,
        ENC_QP      = 2'd1,
        ENC_BASE64  = 2'd2,
        ENC_BINARY  = 2'd3
    } t_enc;

    typedef enum logic [1:0] {
        CON_7BIT   = 2'd0,
        CON_8BIT   = 2'd1,
        CON_BINARY = 2'd2
    } t_con;

    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_CHANNEL = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;
    localparam logic [1:0] REG_PERCENT = 2'd3;

    localparam logic                  RST_ENABLE  = 1'b1;
    localparam logic [1:0]            RST_CHANNEL = CON_7BIT;
    localparam logic [LIMIT_BITS-1:0] RST_LIMIT   = LIMIT_BITS'(998);
    localparam logic [PCT_BITS-1:0]   RST_PERCENT = PCT_BITS'(17);

    typedef struct packed {
        logic                  enable;
        logic [1:0]            channel;
        logic [LIMIT_BITS-1:0] line_limit;
        logic [PCT_BITS-1:0]   percent;
    } t_cfg;

    typedef struct packed {
        logic                 nul_seen;
        logic                 high_seen;
        logic [LINE_BITS-1:0] longest;
        logic                 from_seen;
        logic                 eos;
    } t_flags;

    typedef struct packed {
        logic [COUNT_BITS-1:0] byte_total;
        logic [COUNT_BITS-1:0] high_count;
        t_flags                flags;
    } t_snap;

    typedef struct packed {
        t_enc                     enc;
        logic                     saw_nul;
        logic                     saw_high_bit;
        logic [OUT_LINE_BITS-1:0] longest_line;
        logic                     saw_from_line;
        logic                     stream_done;
    } t_result;

    typedef struct packed {
        logic take;
        logic load2;
        logic load3;
    } t_pipe_ctl;

    function automatic logic [7:0] from_char(input logic [PROG_BITS-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h46;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h6D;
            3'd4:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* src/mtep_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtep_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mtep_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [mtep_pkg::DATA_BITS-1:0] pwdata,
    output logic      [mtep_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready,
    output mtep_pkg::t_cfg                      o_cfg
);
    import mtep_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= RST_ENABLE;
            r_cfg.channel    <= RST_CHANNEL;
            r_cfg.line_limit <= RST_LIMIT;
            r_cfg.percent    <= RST_PERCENT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE:  r_cfg.enable     <= pwdata[0];
                REG_CHANNEL: r_cfg.channel    <= pwdata[1:0];
                REG_LIMIT:   r_cfg.line_limit <= pwdata[LIMIT_BITS-1:0];
                REG_PERCENT: r_cfg.percent    <= pwdata[PCT_BITS-1:0];
                default:     r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE:  prdata = DATA_BITS'(r_cfg.enable);
            REG_CHANNEL: prdata = DATA_BITS'(r_cfg.channel);
            REG_LIMIT:   prdata = DATA_BITS'(r_cfg.line_limit);
            REG_PERCENT: prdata = DATA_BITS'(r_cfg.percent);
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/mtep_stats.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtep_stats (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_stream,
    output mtep_pkg::t_snap o_snap
);
    import mtep_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [LINE_BITS-1:0]  LN_MAX  = '1;

    logic [COUNT_BITS-1:0] r_total, n_total;
    logic [COUNT_BITS-1:0] r_high, n_high;
    logic                  r_nul, n_nul;
    logic [LINE_BITS-1:0]  r_len, n_len;
    logic [LINE_BITS-1:0]  r_max, n_max;
    logic [PROG_BITS-1:0]  r_prog, n_prog;
    logic                  r_live, n_live;
    logic                  r_from, n_from;
    t_snap                 r_snap, n_snap;
    logic [PROG_BITS-1:0]  prog_inc;

    assign prog_inc = r_prog + PROG_BITS'(1);

    always_comb begin
        n_total = (r_total == CNT_MAX) ? r_total : r_total + COUNT_BITS'(1);
        n_nul   = r_nul || (i_data_byte == NUL_CHAR);
        n_high  = r_high;
        if (i_data_byte[7] && (r_high != CNT_MAX)) begin
            n_high = r_high + COUNT_BITS'(1);
        end
        n_len  = r_len;
        n_max  = r_max;
        n_prog = r_prog;
        n_live = r_live;
        n_from = r_from;
        if (i_data_byte == NEWLINE_CHAR) begin
            if (r_len > r_max) begin
                n_max = r_len;
            end
            n_len  = '0;
            n_live = 1'b1;
            n_prog = '0;
        end else begin
            n_len = (r_len == LN_MAX) ? r_len : r_len + LINE_BITS'(1);
            if (r_live) begin
                if ((r_prog < FROM_LEN) && (i_data_byte == from_char(r_prog))) begin
                    n_prog = prog_inc;
                    if (prog_inc == FROM_LEN) begin
                        n_from = 1'b1;
                        n_live = 1'b0;
                    end
                end else begin
                    n_live = 1'b0;
                end
            end
        end
        n_snap.byte_total      = n_total;
        n_snap.high_count      = n_high;
        n_snap.flags.nul_seen  = n_nul;
        n_snap.flags.high_seen = (n_high != '0);
        n_snap.flags.longest   = (n_len > n_max) ? n_len : n_max;
        n_snap.flags.from_seen = n_from;
        n_snap.flags.eos       = i_end_of_stream;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end_of_stream)) begin
            r_total <= '0;
            r_high  <= '0;
            r_nul   <= 1'b0;
            r_len   <= '0;
            r_max   <= '0;
            r_prog  <= '0;
            r_live  <= 1'b1;
            r_from  <= 1'b0;
        end else if (i_take) begin
            r_total <= n_total;
            r_high  <= n_high;
            r_nul   <= n_nul;
            r_len   <= n_len;
            r_max   <= n_max;
            r_prog  <= n_prog;
            r_live  <= n_live;
            r_from  <= n_from;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap = r_snap;

endmodule

`default_nettype wire

/* src/mtep_decide.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtep_decide (
    input  wire logic            i_clk,
    input  wire logic            i_load2,
    input  wire logic            i_load3,
    input  wire mtep_pkg::t_snap i_snap,
    input  wire mtep_pkg::t_cfg  i_cfg,
    output mtep_pkg::t_result    o_result
);
    import mtep_pkg::*;

    localparam logic [CMP_BITS-1:0] OUT_MAX = CMP_BITS'({OUT_LINE_BITS{1'b1}});

    logic [PROD_BITS-1:0] r_prod_a, n_prod_a;
    logic [PROD_BITS-1:0] r_prod_b, n_prod_b;
    t_flags               r_flags;
    t_result              r_result, n_result;
    logic                 b64_wins;
    logic                 too_long;
    logic [CMP_BITS-1:0]  longest_ext;
    t_enc                 enc;

    assign n_prod_a = PROD_BITS'(i_cfg.percent) * PROD_BITS'(i_snap.byte_total);
    assign n_prod_b = (PROD_BITS'(i_snap.high_count) + PROD_BITS'(1)) * PROD_BITS'(B64_SCALE);

    always_ff @(posedge i_clk) begin
        if (i_load2) begin
            r_prod_a <= n_prod_a;
            r_prod_b <= n_prod_b;
            r_flags  <= i_snap.flags;
        end
    end

    assign b64_wins    = r_prod_a < r_prod_b;
    assign longest_ext = CMP_BITS'(r_flags.longest);
    assign too_long    = longest_ext > CMP_BITS'(i_cfg.line_limit);

    always_comb begin
        enc = ENC_DEFAULT;
        if (i_cfg.enable) begin
            unique case (i_cfg.channel)
                CON_7BIT: begin
                    if (r_flags.nul_seen) begin
                        enc = ENC_BASE64;
                    end else if (r_flags.high_seen) begin
                        enc = b64_wins ? ENC_BASE64 : ENC_QP;
                    end else if (too_long) begin
                        enc = ENC_QP;
                    end
                end
                CON_8BIT: begin
                    if (r_flags.nul_seen) begin
                        enc = ENC_BASE64;
                    end else if (too_long) begin
                        enc = ENC_QP;
                    end
                end
                CON_BINARY: begin
                    if (r_flags.nul_seen || r_flags.high_seen) begin
                        enc = ENC_BINARY;
                    end
                end
                default: enc = ENC_DEFAULT;
            endcase
            if ((enc == ENC_DEFAULT) && r_flags.from_seen) begin
                enc = ENC_QP;
            end
        end
        n_result.enc           = enc;
        n_result.saw_nul       = r_flags.nul_seen;
        n_result.saw_high_bit  = r_flags.high_seen;
        n_result.longest_line  = (longest_ext > OUT_MAX) ? '1
                                 : OUT_LINE_BITS'(longest_ext);
        n_result.saw_from_line = r_flags.from_seen;
        n_result.stream_done   = r_flags.eos;
    end

    always_ff @(posedge i_clk) begin
        if (i_load3) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

/* src/mime_transfer_encoding_picker_top.sv */
// channel | valid   | stall   | payload
// --------+---------+---------+-------------------------------------------------
// byte in | i_valid | o_stall | i_data_byte, i_end_of_stream
// result  | o_valid | i_stall | o_encoding_choice, o_saw_nul, o_saw_high_bit,
//         |         |         | o_longest_line, o_saw_from_line, o_stream_done
// config  | APB     | pready  | paddr, pwdata, prdata
//
// One item per clock while o_stall is low; an accepted byte passes through the
// statistics register, product register and result register before o_valid rises.
// Each stage moves when the next one is empty or moving, so a stall on the
// result side fills the bubbles before o_stall rises.
// Synchronous active-low reset clears statistics and stage valids and loads config defaults.
`timescale 1ns / 1ps
`default_nettype none

module mime_transfer_encoding_picker_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_end_of_stream,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [1:0]                          o_encoding_choice,
    output logic                                o_saw_nul,
    output logic                                o_saw_high_bit,
    output logic [mtep_pkg::OUT_LINE_BITS-1:0]  o_longest_line,
    output logic                                o_saw_from_line,
    output logic                                o_stream_done,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mtep_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [mtep_pkg::DATA_BITS-1:0] pwdata,
    output logic      [mtep_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready
);
    import mtep_pkg::*;

    logic      r_v1, r_v2, r_v3;
    logic      adv1, adv2, adv3;
    t_pipe_ctl ctl;
    t_cfg      cfg;
    t_snap     snap;
    t_result   result;

    assign adv3      = !r_v3 || !i_stall;
    assign adv2      = !r_v2 || adv3;
    assign adv1      = !r_v1 || adv2;
    assign o_stall   = !adv1;
    assign ctl.take  = i_valid && adv1;
    assign ctl.load2 = adv2 && r_v1;
    assign ctl.load3 = adv3 && r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= ctl.take;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    mtep_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mtep_stats u_stats (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (ctl.take),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_snap          (snap)
    );

    mtep_decide u_decide (
        .i_clk    (i_clk),
        .i_load2  (ctl.load2),
        .i_load3  (ctl.load3),
        .i_snap   (snap),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_valid           = r_v3;
    assign o_encoding_choice = result.enc;
    assign o_saw_nul         = result.saw_nul;
    assign o_saw_high_bit    = result.saw_high_bit;
    assign o_longest_line    = result.longest_line;
    assign o_saw_from_line   = result.saw_from_line;
    assign o_stream_done     = result.stream_done;

endmodule

`default_nettype wire

/* src/mtep_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mtep_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_stall,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire logic [1:0]                        o_encoding_choice,
    input wire logic                              o_saw_nul,
    input wire logic                              o_saw_high_bit,
    input wire logic [mtep_pkg::OUT_LINE_BITS-1:0] o_longest_line,
    input wire logic                              o_saw_from_line
);
    import mtep_pkg::*;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_encoding_choice)
                               && $stable(o_longest_line))
        else $error("result changed while stalled");

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    a_binary_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_encoding_choice == ENC_BINARY) |-> o_saw_nul || o_saw_high_bit)
        else $error("binary chosen without nul or high-bit byte");

    a_from_needs_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saw_from_line |-> (o_longest_line != '0))
        else $error("from line reported with no line content");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind mime_transfer_encoding_picker_top mtep_checker u_chk (.*);

`default_nettype wire

/* tb/mime_transfer_encoding_picker_top_test.sv */
`timescale 1ns / 1ps

module mime_transfer_encoding_picker_top_test;
    import mtep_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 60;
    localparam int NUM_PHASES    = 8;
    localparam int LONG_LINE     = 48;
    localparam int INTRO_ROWS    = 25;
    localparam logic [1:0]  CON_UNUSED = 2'd3;
    localparam logic [39:0] FROM_TEXT  = "From ";

    typedef struct packed {
        logic [7:0]           data;
        logic                 eos;
        logic                 typed;
        t_enc                 enc;
        logic                 nul;
        logic                 high;
        logic [LINE_BITS-1:0] longest;
        logic                 from_line;
    } t_intro_row;

    t_intro_row intro_rows [INTRO_ROWS] = '{
        '{8'h41, 1'b0, 1'b1, ENC_DEFAULT, 1'b0, 1'b0, 16'd1, 1'b0},
        '{8'h00, 1'b1, 1'b1, ENC_BASE64,  1'b1, 1'b0, 16'd2, 1'b0},
        '{8'h46, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h72, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h6F, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h6D, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h20, 1'b0, 1'b1, ENC_QP,      1'b0, 1'b0, 16'd5, 1'b1},
        '{8'h0A, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h0A, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h0A, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h01, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hFE, 1'b1, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, ENC_BASE64,  1'b0, 1'b1, 16'd1, 1'b0},
        '{8'h0A, 1'b1, 1'b1, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h20, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h46, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h0A, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h46, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h72, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h6F, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h6D, 1'b0, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h20, 1'b1, 1'b0, ENC_DEFAULT, 1'b0, 1'b0, 16'd0, 1'b0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_end_of_stream = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [1:0]           o_encoding_choice;
    logic                 o_saw_nul;
    logic                 o_saw_high_bit;
    logic [OUT_LINE_BITS-1:0] o_longest_line;
    logic                 o_saw_from_line;
    logic                 o_stream_done;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    logic                  cfg_enable  = RST_ENABLE;
    logic [1:0]            cfg_channel = RST_CHANNEL;
    logic [LIMIT_BITS-1:0] cfg_limit   = RST_LIMIT;
    logic [PCT_BITS-1:0]   cfg_pct     = RST_PERCENT;

    logic [COUNT_BITS-1:0] stat_bytes  = '0;
    logic [COUNT_BITS-1:0] stat_nuls   = '0;
    logic [COUNT_BITS-1:0] stat_highs  = '0;
    logic [LINE_BITS-1:0]  open_line   = '0;
    logic [LINE_BITS-1:0]  widest_line = '0;
    logic [PROG_BITS-1:0]  from_pos    = '0;
    logic                  from_armed  = 1'b1;
    logic                  from_found  = 1'b0;

    t_result verdicts_due [$];
    int      mismatches   = 0;
    int      cycle_count  = 0;
    int      bytes_sent   = 0;
    int      tx_idle_pct  = 0;
    int      rx_stall_pct = 0;

    mime_transfer_encoding_picker_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_stream   (i_end_of_stream),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_encoding_choice (o_encoding_choice),
        .o_saw_nul         (o_saw_nul),
        .o_saw_high_bit    (o_saw_high_bit),
        .o_longest_line    (o_longest_line),
        .o_saw_from_line   (o_saw_from_line),
        .o_stream_done     (o_stream_done),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result advance_stats(input logic [7:0] b, input logic eos);
        t_result              r;
        logic [LINE_BITS-1:0] longest;
        logic [47:0]          share_lhs;
        logic [47:0]          share_rhs;
        t_enc                 enc;
        if (stat_bytes != '1) stat_bytes++;
        if (b == NUL_CHAR) begin
            if (stat_nuls != '1) stat_nuls++;
        end else if (b[7]) begin
            if (stat_highs != '1) stat_highs++;
        end
        if (b == NEWLINE_CHAR) begin
            if (open_line > widest_line) widest_line = open_line;
            open_line  = '0;
            from_armed = 1'b1;
            from_pos   = '0;
        end else begin
            if (open_line != '1) open_line++;
            if (from_armed) begin
                if (from_pos < FROM_LEN && b == FROM_TEXT[39 - 8 * int'(from_pos) -: 8]) begin
                    from_pos++;
                    if (from_pos == FROM_LEN) begin
                        from_found = 1'b1;
                        from_armed = 1'b0;
                    end
                end else begin
                    from_armed = 1'b0;
                end
            end
        end
        longest   = (open_line > widest_line) ? open_line : widest_line;
        share_lhs = 48'(cfg_pct) * 48'(stat_bytes);
        share_rhs = (48'(stat_highs) + 48'd1) * 48'(B64_SCALE);
        enc = ENC_DEFAULT;
        if (cfg_enable) begin
            case (cfg_channel)
                CON_7BIT: begin
                    if (stat_nuls != 0) enc = ENC_BASE64;
                    else if (stat_highs != 0)
                        enc = (share_lhs < share_rhs) ? ENC_BASE64 : ENC_QP;
                    else if (longest > cfg_limit) enc = ENC_QP;
                end
                CON_8BIT: begin
                    if (stat_nuls != 0) enc = ENC_BASE64;
                    else if (longest > cfg_limit) enc = ENC_QP;
                end
                CON_BINARY: begin
                    if (stat_nuls != 0 || stat_highs != 0) enc = ENC_BINARY;
                end
                default: ;
            endcase
            if (enc == ENC_DEFAULT && from_found) enc = ENC_QP;
        end
        r.enc           = enc;
        r.saw_nul       = (stat_nuls != 0);
        r.saw_high_bit  = (stat_highs != 0);
        r.longest_line  = longest;
        r.saw_from_line = from_found;
        r.stream_done   = eos;
        if (eos) begin
            stat_bytes  = '0;
            stat_nuls   = '0;
            stat_highs  = '0;
            open_line   = '0;
            widest_line = '0;
            from_pos    = '0;
            from_armed  = 1'b1;
            from_found  = 1'b0;
        end
        return r;
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts_due.size() == 0) begin
                note_error($sformatf("unexpected result enc=%0d line=%0d",
                                     o_encoding_choice, o_longest_line));
            end else begin
                want = verdicts_due.pop_front();
                if (o_encoding_choice !== want.enc || o_saw_nul !== want.saw_nul ||
                    o_saw_high_bit !== want.saw_high_bit ||
                    o_longest_line !== want.longest_line ||
                    o_saw_from_line !== want.saw_from_line ||
                    o_stream_done !== want.stream_done) begin
                    note_error($sformatf({"exp enc=%0d nul=%0b high=%0b line=%0d from=%0b ",
                                          "done=%0b, got enc=%0d nul=%0b high=%0b line=%0d ",
                                          "from=%0b done=%0b"},
                                         want.enc, want.saw_nul, want.saw_high_bit,
                                         want.longest_line, want.saw_from_line,
                                         want.stream_done, o_encoding_choice, o_saw_nul,
                                         o_saw_high_bit, o_longest_line, o_saw_from_line,
                                         o_stream_done));
                end
            end
        end
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= eos;
        do @(posedge i_clk); while (o_stall);
        verdicts_due.push_back(advance_stats(b, eos));
        bytes_sent++;
    endtask

    task automatic send_random_line();
        int         len;
        int         hi_share;
        int         nul_share;
        int         r;
        int         k;
        logic [7:0] b;
        hi_share  = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 15);
        nul_share = ($urandom_range(3) == 0) ? 3 : 0;
        r = $urandom_range(9);
        if (r < 3) k = 5;
        else if (r == 3) k = $urandom_range(1, 4);
        else k = 0;
        for (int i = 0; i < k; i++) send_byte(FROM_TEXT[39 - 8 * i -: 8], 1'b0);
        len = ($urandom_range(7) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
        repeat (len) begin
            r = $urandom_range(99);
            if (r < hi_share) b = 8'($urandom_range(128, 255));
            else if (r < hi_share + nul_share) b = NUL_CHAR;
            else if (r < hi_share + nul_share + 6) b = 8'($urandom);
            else b = 8'($urandom_range(32, 126));
            send_byte(b, $urandom_range(59) == 0);
        end
        if ($urandom_range(7) != 0) send_byte(NEWLINE_CHAR, $urandom_range(29) == 0);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] value);
        logic [DATA_BITS-1:0] readback;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_ENABLE:  cfg_enable  = value[0];
            REG_CHANNEL: cfg_channel = value[1:0];
            REG_LIMIT:   cfg_limit   = value[LIMIT_BITS-1:0];
            REG_PERCENT: cfg_pct     = value[PCT_BITS-1:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== value)
            note_error($sformatf("register %0d read %0h, wrote %0h", idx, readback, value));
    endtask

    task automatic apply_config(input logic en, input logic [1:0] ch,
                                input logic [LIMIT_BITS-1:0] lim,
                                input logic [PCT_BITS-1:0] pct);
        program_reg(REG_ENABLE, DATA_BITS'(en));
        program_reg(REG_CHANNEL, DATA_BITS'(ch));
        program_reg(REG_LIMIT, DATA_BITS'(lim));
        program_reg(REG_PERCENT, DATA_BITS'(pct));
    endtask

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** mime_transfer_encoding_picker_top: FAILED **");
        $finish;
    end

    initial begin
        t_result typed_res;
        int      quota;
        bit      paused;
        paused = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < INTRO_ROWS; i++) begin
            send_byte(intro_rows[i].data, intro_rows[i].eos);
            if (intro_rows[i].typed) begin
                typed_res.enc           = intro_rows[i].enc;
                typed_res.saw_nul       = intro_rows[i].nul;
                typed_res.saw_high_bit  = intro_rows[i].high;
                typed_res.longest_line  = intro_rows[i].longest;
                typed_res.saw_from_line = intro_rows[i].from_line;
                typed_res.stream_done   = intro_rows[i].eos;
                verdicts_due[verdicts_due.size() - 1] = typed_res;
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: apply_config(1'b1, CON_8BIT, 16'd0, 7'd0);
                1: apply_config(1'b1, CON_BINARY, 16'hFFFF, 7'd100);
                2: apply_config(1'b1, CON_UNUSED, 16'd30, 7'd127);
                3: apply_config(1'b0, CON_7BIT, 16'd10, 7'd50);
                4: apply_config(1'b1, CON_7BIT, 16'd25, 7'd127);
                5: apply_config(1'b1, CON_7BIT, 16'd40, 7'd0);
                default: apply_config($urandom_range(4) != 0, 2'($urandom_range(3)),
                                      16'($urandom_range(0, 80)), 7'($urandom_range(0, 127)));
            endcase
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
            endcase
            quota = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < quota) begin
                send_random_line();
                if (phase == 1 && !paused && bytes_sent >= quota - PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        apply_config(1'b1, CON_7BIT, 16'd40, RST_PERCENT);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (LONG_LINE) send_byte(8'h78, 1'b0);
        send_byte(NEWLINE_CHAR, 1'b0);
        send_byte(8'h41, 1'b1);

        drain_results();
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("** mime_transfer_encoding_picker_top: PASSED **");
        end else begin
            $display("** mime_transfer_encoding_picker_top: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
src/mtep_pkg.sv
src/mtep_regs.sv
src/mtep_stats.sv
src/mtep_decide.sv
src/mime_transfer_encoding_picker_top.sv
src/mtep_checker.sv
tb/mime_transfer_encoding_picker_top_test.sv
